[hdl/rmth_pkg.sv]
// ---------------------------------------------------------------------------
// rmth_pkg
// shared types for the running median two-heap block
// ---------------------------------------------------------------------------
package rmth_pkg;

    localparam logic HEAP_LOWER = 1'b0;
    localparam logic HEAP_UPPER = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE     = 4'd0,
        OP_LOAD     = 4'd1,
        OP_ROUTE    = 4'd2,
        OP_PU_INIT  = 4'd3,
        OP_PU_CHK   = 4'd4,
        OP_PU_STEP  = 4'd5,
        OP_POP_INIT = 4'd6,
        OP_POP_LOAD = 4'd7,
        OP_SD_KEY   = 4'd8,
        OP_SD_CHK   = 4'd9,
        OP_SD_L     = 4'd10,
        OP_SD_R     = 4'd11,
        OP_SD_DEC   = 4'd12,
        OP_FINISH   = 4'd13
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   sel;
        logic   use_carry;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic go_upper;
        logic lower_full;
        logic key_ge_lroot;
        logic u_gt_l;
        logic l_gt_u1;
        logic pu_done;
        logic sd_done;
        logic r_ok;
    } sts_t;

endpackage

[hdl/rmth_ram.sv]
// ---------------------------------------------------------------------------
// rmth_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
module rmth_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/rmth_datapath.sv]
// ---------------------------------------------------------------------------
// rmth_datapath
// heap memories, counts, roots and sift registers
// ---------------------------------------------------------------------------
module rmth_datapath #(
    parameter int HEAP_DEPTH  = 512,
    parameter int SAMPLE_BITS = 32,
    parameter int CNTW        = 11
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rmth_pkg::cmd_t                cmd,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          restart,
    output rmth_pkg::sts_t                sts,
    output logic signed [SAMPLE_BITS-1:0] median,
    output logic [CNTW-1:0]               count,
    output logic                          overflow
);

    localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int CW = AW + 1;
    localparam int LW = AW + 2;

    logic [CW-1:0] lcnt_reg, ucnt_reg;
    logic signed [SAMPLE_BITS-1:0] key_reg, val_reg, bval_reg, carry_reg;
    logic signed [SAMPLE_BITS-1:0] lroot_reg, uroot_reg;
    logic [AW-1:0] pos_reg, best_reg;
    logic          bpos_reg, ovf_reg;

    logic                    we, re;
    logic [AW-1:0]           waddr, raddr;
    logic [SAMPLE_BITS-1:0]  wdata, rd_l, rd_u;
    logic signed [SAMPLE_BITS-1:0] rd, root_sel;
    logic [CW-1:0]           cnt_sel;
    logic [CW:0]             total;
    logic [LW-1:0]           l_idx, r_idx, n_ext;
    logic [AW-1:0]           parent;
    logic                    l_ok, r_ok;
    logic                    a_val_rd, a_rd_val, a_rd_bval;

    function automatic logic ahead(input logic signed [SAMPLE_BITS-1:0] a,
                                   input logic signed [SAMPLE_BITS-1:0] b,
                                   input logic is_upper);
        ahead = is_upper ? (a < b) : (a > b);
    endfunction

    rmth_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(HEAP_DEPTH)) u_lower (
        .clk(clk), .we(we && cmd.sel == rmth_pkg::HEAP_LOWER), .waddr(waddr),
        .wdata(wdata), .re(re), .raddr(raddr), .rdata(rd_l)
    );

    rmth_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(HEAP_DEPTH)) u_upper (
        .clk(clk), .we(we && cmd.sel == rmth_pkg::HEAP_UPPER), .waddr(waddr),
        .wdata(wdata), .re(re), .raddr(raddr), .rdata(rd_u)
    );

    assign rd       = $signed((cmd.sel == rmth_pkg::HEAP_UPPER) ? rd_u : rd_l);
    assign cnt_sel  = (cmd.sel == rmth_pkg::HEAP_UPPER) ? ucnt_reg : lcnt_reg;
    assign root_sel = (cmd.sel == rmth_pkg::HEAP_UPPER) ? uroot_reg : lroot_reg;
    assign total    = {1'b0, lcnt_reg} + {1'b0, ucnt_reg};
    assign l_idx    = {1'b0, pos_reg, 1'b1};
    assign r_idx    = ({2'b00, pos_reg} + LW'(1)) << 1;
    assign n_ext    = LW'(cnt_sel);
    assign l_ok     = l_idx < n_ext;
    assign r_ok     = r_idx < n_ext;
    assign parent   = (pos_reg - AW'(1)) >> 1;
    assign a_val_rd  = ahead(val_reg, rd, cmd.sel);
    assign a_rd_val  = ahead(rd, val_reg, cmd.sel);
    assign a_rd_bval = ahead(rd, bval_reg, cmd.sel);

    always_comb
    begin
        we    = 1'b0;
        re    = 1'b0;
        waddr = pos_reg;
        wdata = val_reg;
        raddr = parent;
        unique case (cmd.op)
            rmth_pkg::OP_PU_CHK:
            begin
                if (pos_reg == '0)
                begin
                    we = 1'b1;
                end
                else
                begin
                    re = 1'b1;
                end
            end
            rmth_pkg::OP_PU_STEP:
            begin
                we = 1'b1;
                if (a_val_rd)
                begin
                    wdata = rd;
                end
            end
            rmth_pkg::OP_POP_INIT:
            begin
                re    = 1'b1;
                raddr = AW'(cnt_sel - CW'(1));
            end
            rmth_pkg::OP_SD_CHK:
            begin
                if (l_ok)
                begin
                    re    = 1'b1;
                    raddr = l_idx[AW-1:0];
                end
                else
                begin
                    we = 1'b1;
                end
            end
            rmth_pkg::OP_SD_L:
            begin
                if (r_ok)
                begin
                    re    = 1'b1;
                    raddr = r_idx[AW-1:0];
                end
            end
            rmth_pkg::OP_SD_DEC:
            begin
                we = 1'b1;
                if (!bpos_reg)
                begin
                    wdata = bval_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcnt_reg <= '0;
            ucnt_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            unique case (cmd.op)
                rmth_pkg::OP_LOAD:
                begin
                    if (restart)
                    begin
                        lcnt_reg <= '0;
                        ucnt_reg <= '0;
                    end
                end
                rmth_pkg::OP_ROUTE:
                begin
                    ovf_reg <= sts.full;
                end
                rmth_pkg::OP_PU_CHK, rmth_pkg::OP_PU_STEP:
                begin
                    if (sts.pu_done)
                    begin
                        if (cmd.sel == rmth_pkg::HEAP_UPPER)
                        begin
                            ucnt_reg <= ucnt_reg + CW'(1);
                        end
                        else
                        begin
                            lcnt_reg <= lcnt_reg + CW'(1);
                        end
                    end
                end
                rmth_pkg::OP_POP_INIT:
                begin
                    if (cmd.sel == rmth_pkg::HEAP_UPPER)
                    begin
                        ucnt_reg <= ucnt_reg - CW'(1);
                    end
                    else
                    begin
                        lcnt_reg <= lcnt_reg - CW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (we && waddr == '0)
        begin
            if (cmd.sel == rmth_pkg::HEAP_UPPER)
            begin
                uroot_reg <= $signed(wdata);
            end
            else
            begin
                lroot_reg <= $signed(wdata);
            end
        end
        unique case (cmd.op)
            rmth_pkg::OP_LOAD:
            begin
                key_reg <= sample;
            end
            rmth_pkg::OP_PU_INIT:
            begin
                pos_reg <= cnt_sel[AW-1:0];
                val_reg <= cmd.use_carry ? carry_reg : key_reg;
            end
            rmth_pkg::OP_PU_STEP:
            begin
                if (a_val_rd)
                begin
                    pos_reg <= parent;
                end
            end
            rmth_pkg::OP_POP_INIT:
            begin
                carry_reg <= root_sel;
                pos_reg   <= '0;
            end
            rmth_pkg::OP_POP_LOAD:
            begin
                val_reg <= rd;
            end
            rmth_pkg::OP_SD_KEY:
            begin
                carry_reg <= lroot_reg;
                val_reg   <= key_reg;
                pos_reg   <= '0;
            end
            rmth_pkg::OP_SD_L:
            begin
                if (a_rd_val)
                begin
                    bval_reg <= rd;
                    best_reg <= l_idx[AW-1:0];
                    bpos_reg <= 1'b0;
                end
                else
                begin
                    bval_reg <= val_reg;
                    bpos_reg <= 1'b1;
                end
            end
            rmth_pkg::OP_SD_R:
            begin
                if (a_rd_bval)
                begin
                    bval_reg <= rd;
                    best_reg <= r_idx[AW-1:0];
                    bpos_reg <= 1'b0;
                end
            end
            rmth_pkg::OP_SD_DEC:
            begin
                if (!bpos_reg)
                begin
                    pos_reg <= best_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // balance checks look at the counts as they stand before the push in progress is counted
    always_comb
    begin
        sts.full         = total >= (CW + 1)'(2 * HEAP_DEPTH);
        sts.go_upper     = (ucnt_reg != '0) && (key_reg > uroot_reg);
        sts.lower_full   = lcnt_reg >= CW'(HEAP_DEPTH);
        sts.key_ge_lroot = key_reg >= lroot_reg;
        sts.u_gt_l       = ucnt_reg >= lcnt_reg;
        sts.l_gt_u1      = lcnt_reg > ucnt_reg;
        sts.pu_done      = (cmd.op == rmth_pkg::OP_PU_CHK && pos_reg == '0) ||
                           (cmd.op == rmth_pkg::OP_PU_STEP && !a_val_rd);
        sts.sd_done      = (cmd.op == rmth_pkg::OP_SD_CHK && !l_ok) ||
                           (cmd.op == rmth_pkg::OP_SD_DEC && bpos_reg);
        sts.r_ok         = r_ok;
    end

    assign median   = (lcnt_reg == '0) ? '0 : lroot_reg;
    assign count    = CNTW'(total);
    assign overflow = ovf_reg;

endmodule

[hdl/rmth_ctrl.sv]
// ---------------------------------------------------------------------------
// rmth_ctrl
// sequencer for insert, pop and sift operations on the two heaps
// ---------------------------------------------------------------------------
module rmth_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  rmth_pkg::sts_t sts,
    output rmth_pkg::cmd_t cmd,
    output logic           busy,
    output logic           done
);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b000000000001,
        S_ROUTE    = 12'b000000000010,
        S_PU_INIT  = 12'b000000000100,
        S_PU_CHK   = 12'b000000001000,
        S_PU_STEP  = 12'b000000010000,
        S_POP_INIT = 12'b000000100000,
        S_POP_LOAD = 12'b000001000000,
        S_SD_KEY   = 12'b000010000000,
        S_SD_CHK   = 12'b000100000000,
        S_SD_L     = 12'b001000000000,
        S_SD_R     = 12'b010000000000,
        S_SD_DEC   = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    logic   sel_reg, sel_next;
    logic   carry_reg, carry_next;
    logic   final_reg, final_next;
    logic   fin_reg, fin_next;

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        carry_next = carry_reg;
        final_next = final_reg;
        fin_next   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_ROUTE;
                end
            end
            S_ROUTE:
            begin
                carry_next = 1'b0;
                if (sts.full)
                begin
                    state_next = S_IDLE;
                    fin_next   = 1'b1;
                end
                else if (sts.go_upper)
                begin
                    sel_next   = rmth_pkg::HEAP_UPPER;
                    final_next = 1'b0;
                    state_next = S_PU_INIT;
                end
                else if (sts.lower_full)
                begin
                    if (sts.key_ge_lroot)
                    begin
                        sel_next   = rmth_pkg::HEAP_UPPER;
                        final_next = 1'b1;
                        state_next = S_PU_INIT;
                    end
                    else
                    begin
                        sel_next   = rmth_pkg::HEAP_LOWER;
                        state_next = S_SD_KEY;
                    end
                end
                else
                begin
                    sel_next   = rmth_pkg::HEAP_LOWER;
                    final_next = 1'b0;
                    state_next = S_PU_INIT;
                end
            end
            S_PU_INIT:
            begin
                state_next = S_PU_CHK;
            end
            S_PU_CHK, S_PU_STEP:
            begin
                if (!sts.pu_done)
                begin
                    state_next = (state_reg == S_PU_CHK) ? S_PU_STEP : S_PU_CHK;
                end
                else if (!final_reg && ((sel_reg == rmth_pkg::HEAP_UPPER) ?
                         sts.u_gt_l : sts.l_gt_u1))
                begin
                    state_next = S_POP_INIT;
                end
                else
                begin
                    state_next = S_IDLE;
                    fin_next   = 1'b1;
                end
            end
            S_POP_INIT:
            begin
                state_next = S_POP_LOAD;
            end
            S_POP_LOAD, S_SD_KEY:
            begin
                state_next = S_SD_CHK;
            end
            S_SD_CHK, S_SD_DEC:
            begin
                if (sts.sd_done)
                begin
                    sel_next   = ~sel_reg;
                    carry_next = 1'b1;
                    final_next = 1'b1;
                    state_next = S_PU_INIT;
                end
                else if (state_reg == S_SD_CHK)
                begin
                    state_next = S_SD_L;
                end
                else
                begin
                    state_next = S_SD_CHK;
                end
            end
            S_SD_L:
            begin
                state_next = sts.r_ok ? S_SD_R : S_SD_DEC;
            end
            S_SD_R:
            begin
                state_next = S_SD_DEC;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= rmth_pkg::HEAP_LOWER;
            carry_reg <= 1'b0;
            final_reg <= 1'b0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            carry_reg <= carry_next;
            final_reg <= final_next;
            fin_reg   <= fin_next;
        end
    end

    // sample and restart are taken at the accepting edge
    always_comb
    begin
        cmd.sel       = sel_reg;
        cmd.use_carry = carry_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op = rmth_pkg::OP_LOAD;
                end
                else
                begin
                    cmd.op = fin_reg ? rmth_pkg::OP_FINISH : rmth_pkg::OP_NONE;
                end
            end
            S_ROUTE:    cmd.op = rmth_pkg::OP_ROUTE;
            S_PU_INIT:  cmd.op = rmth_pkg::OP_PU_INIT;
            S_PU_CHK:   cmd.op = rmth_pkg::OP_PU_CHK;
            S_PU_STEP:  cmd.op = rmth_pkg::OP_PU_STEP;
            S_POP_INIT: cmd.op = rmth_pkg::OP_POP_INIT;
            S_POP_LOAD: cmd.op = rmth_pkg::OP_POP_LOAD;
            S_SD_KEY:   cmd.op = rmth_pkg::OP_SD_KEY;
            S_SD_CHK:   cmd.op = rmth_pkg::OP_SD_CHK;
            S_SD_L:     cmd.op = rmth_pkg::OP_SD_L;
            S_SD_R:     cmd.op = rmth_pkg::OP_SD_R;
            S_SD_DEC:   cmd.op = rmth_pkg::OP_SD_DEC;
            default:    cmd.op = rmth_pkg::OP_NONE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = fin_reg;

endmodule

[hdl/running_median_two_heaps_top.sv]
// ---------------------------------------------------------------------------
// running_median_two_heaps_top
// running lower median over a max-heap / min-heap pair
//
//   channel  signals                         handshake
//   input    sample, restart                 start high while busy low
//   result   median, count, overflow         done strobe, one cycle
//
// for a dropped sample the done strobe follows the routing step directly;
// otherwise a heap insert reads the parent and writes once per level, a
// root removal reads the children in turn and writes once per level, each
// level limited by the single read port of the heap memory.
// reset clears both counts at once; heap memories need no clearing.
// the result is shown for one cycle and cannot be stalled.
// ---------------------------------------------------------------------------
module running_median_two_heaps_top #(
    parameter int HEAP_DEPTH  = 512,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          restart,
    output logic                          done,
    output logic signed [SAMPLE_BITS-1:0] median,
    output logic [$clog2(2*HEAP_DEPTH+1)-1:0] count,
    output logic                          overflow
);

    localparam int CNTW = $clog2(2 * HEAP_DEPTH + 1);

    rmth_pkg::cmd_t cmd;
    rmth_pkg::sts_t sts;

    rmth_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .sts(sts),
        .cmd(cmd), .busy(busy), .done(done)
    );

    rmth_datapath #(
        .HEAP_DEPTH(HEAP_DEPTH), .SAMPLE_BITS(SAMPLE_BITS), .CNTW(CNTW)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sample(sample),
        .restart(restart), .sts(sts), .median(median), .count(count),
        .overflow(overflow)
    );

`ifndef ASSERT_OFF
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result while busy");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("transaction not taken");
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> count <= CNTW'(2 * HEAP_DEPTH)) else $error("count too large");
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        done && overflow |-> count == CNTW'(2 * HEAP_DEPTH))
        else $error("overflow while not full");
`endif

endmodule

[dv/tb_running_median_two_heaps_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_running_median_two_heaps_top
// self-checking bench for the running lower median block
//
// a predictor keeps its own pair of heaps and works out the median, count
// and drop flag for every accepted transaction. Directed tests cover
// extreme values, restart, a full store with drops, and the full lower
// heap case. They are followed by a long random stream with restarts.
// Gaps of random length fall between transactions.
// ---------------------------------------------------------------------------
module tb_running_median_two_heaps_top;

    localparam int DEPTH = 512;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        logic signed [31:0] median;
        logic [10:0]        count;
        logic               overflow;
    } median_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic signed [31:0] sample = '0;
    logic               restart = 1'b0;
    logic               busy;
    logic               done;
    logic signed [31:0] median;
    logic [10:0]        count;
    logic               overflow;

    logic signed [31:0] heap_mem [2][DEPTH];
    int                 heap_n [2];
    median_result_t     pending_q [$];
    int                 fail_count = 0;
    int                 sent_count = 0;
    int                 checked_count = 0;
    int                 drop_count = 0;
    int                 cycle_count = 0;
    bit                 no_gaps = 1'b0;

    running_median_two_heaps_top #(.HEAP_DEPTH(DEPTH), .SAMPLE_BITS(32)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .sample(sample), .restart(restart), .done(done),
        .median(median), .count(count), .overflow(overflow)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic bit outranks(logic which, logic signed [31:0] a, logic signed [31:0] b);
        return (which == rmth_pkg::HEAP_LOWER) ? (a > b) : (a < b);
    endfunction

    function automatic void heap_sift_down(logic which);
        int pos;
        int best;
        int l;
        logic signed [31:0] t;
        pos = 0;
        forever
        begin
            best = pos;
            l = 2 * pos + 1;
            if (l < heap_n[which] && outranks(which, heap_mem[which][l], heap_mem[which][best]))
                best = l;
            if (l + 1 < heap_n[which] &&
                outranks(which, heap_mem[which][l + 1], heap_mem[which][best]))
                best = l + 1;
            if (best == pos)
                break;
            t = heap_mem[which][pos];
            heap_mem[which][pos] = heap_mem[which][best];
            heap_mem[which][best] = t;
            pos = best;
        end
    endfunction

    function automatic void heap_insert(logic which, logic signed [31:0] v);
        int pos;
        int parent;
        logic signed [31:0] t;
        if (heap_n[which] >= DEPTH)
            return;
        pos = heap_n[which];
        heap_mem[which][pos] = v;
        while (pos > 0)
        begin
            parent = (pos - 1) / 2;
            if (!outranks(which, heap_mem[which][pos], heap_mem[which][parent]))
                break;
            t = heap_mem[which][pos];
            heap_mem[which][pos] = heap_mem[which][parent];
            heap_mem[which][parent] = t;
            pos = parent;
        end
        heap_n[which]++;
    endfunction

    function automatic logic signed [31:0] heap_remove_root(logic which);
        logic signed [31:0] root;
        root = heap_mem[which][0];
        heap_n[which]--;
        heap_mem[which][0] = heap_mem[which][heap_n[which]];
        heap_sift_down(which);
        return root;
    endfunction

    function automatic median_result_t predict_median(logic signed [31:0] s, logic clr);
        median_result_t r;
        logic signed [31:0] top;
        r.overflow = 1'b0;
        if (clr)
        begin
            heap_n[rmth_pkg::HEAP_LOWER] = 0;
            heap_n[rmth_pkg::HEAP_UPPER] = 0;
        end
        if (heap_n[rmth_pkg::HEAP_LOWER] + heap_n[rmth_pkg::HEAP_UPPER] >= 2 * DEPTH)
            r.overflow = 1'b1;
        else if (heap_n[rmth_pkg::HEAP_UPPER] > 0 && s > heap_mem[rmth_pkg::HEAP_UPPER][0])
        begin
            heap_insert(rmth_pkg::HEAP_UPPER, s);
            if (heap_n[rmth_pkg::HEAP_UPPER] > heap_n[rmth_pkg::HEAP_LOWER])
                heap_insert(rmth_pkg::HEAP_LOWER, heap_remove_root(rmth_pkg::HEAP_UPPER));
        end
        else if (heap_n[rmth_pkg::HEAP_LOWER] >= DEPTH)
        begin
            if (s >= heap_mem[rmth_pkg::HEAP_LOWER][0])
                heap_insert(rmth_pkg::HEAP_UPPER, s);
            else
            begin
                top = heap_mem[rmth_pkg::HEAP_LOWER][0];
                heap_mem[rmth_pkg::HEAP_LOWER][0] = s;
                heap_sift_down(rmth_pkg::HEAP_LOWER);
                heap_insert(rmth_pkg::HEAP_UPPER, top);
            end
        end
        else
        begin
            heap_insert(rmth_pkg::HEAP_LOWER, s);
            if (heap_n[rmth_pkg::HEAP_LOWER] > heap_n[rmth_pkg::HEAP_UPPER] + 1)
                heap_insert(rmth_pkg::HEAP_UPPER, heap_remove_root(rmth_pkg::HEAP_LOWER));
        end
        r.median = (heap_n[rmth_pkg::HEAP_LOWER] > 0) ? heap_mem[rmth_pkg::HEAP_LOWER][0] : '0;
        r.count = 11'(heap_n[rmth_pkg::HEAP_LOWER] + heap_n[rmth_pkg::HEAP_UPPER]);
        return r;
    endfunction

    // result check
    always @(posedge clk)
    begin
        median_result_t e;
        if (rst_n && done)
        begin
            if (pending_q.size() == 0)
            begin
                $display("%0t: result with no transaction pending", $time);
                fail_count++;
            end
            else
            begin
                e = pending_q.pop_front();
                checked_count++;
                if (e.overflow)
                    drop_count++;
                if (median !== e.median)
                begin
                    $display("%0t: median expected %0d actual %0d", $time, e.median, median);
                    fail_count++;
                end
                if (count !== e.count)
                begin
                    $display("%0t: count expected %0d actual %0d", $time, e.count, count);
                    fail_count++;
                end
                if (overflow !== e.overflow)
                begin
                    $display("%0t: overflow expected %0b actual %0b", $time, e.overflow,
                             overflow);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_sample(logic signed [31:0] s, logic clr);
        int gap;
        int pick;
        start <= 1'b1;
        sample <= s;
        restart <= clr;
        do
            @(posedge clk);
        while (busy);
        pending_q = {pending_q, predict_median(s, clr)};
        sent_count++;
        pick = $urandom_range(99);
        if (no_gaps || pick < 50)
            gap = 0;
        else if (pick < 92)
            gap = $urandom_range(3, 1);
        else
            gap = $urandom_range(80, 10);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return (pick < 5) ? 32'sh7fffffff : 32'sh80000000;
        else if (pick < 45)
            return $signed(32'($urandom_range(20))) - 10;
        else
            return $signed($urandom);
    endfunction

    task automatic test_extremes();
        send_sample(32'sh80000000, 1'b1);
        send_sample(32'sh7fffffff, 1'b0);
        send_sample(32'sh7fffffff, 1'b0);
        send_sample(32'sh80000000, 1'b0);
        send_sample(0, 1'b0);
        send_sample(-1, 1'b0);
        send_sample(1, 1'b0);
        send_sample(5, 1'b0);
        send_sample(5, 1'b0);
        send_sample(32'sh55555555, 1'b0);
        send_sample(32'shaaaaaaaa, 1'b0);
        send_sample(-1, 1'b1);
        send_sample(-1, 1'b0);
        send_sample(32'sh7fffffff, 1'b1);
        send_sample(3, 1'b0);
        send_sample(2, 1'b0);
        send_sample(1, 1'b0);
        send_sample(0, 1'b0);
        wait_drained();
    endtask

    // fill to 1024 and keep going to get drops; ascending values make the
    // lower heap fill while the upper one still has room
    task automatic test_full_store(bit ascending);
        send_sample(ascending ? 32'sh80000000 : 32'sh7fffffff, 1'b1);
        for (int i = 1; i < 2 * DEPTH - 1; i++)
            send_sample(ascending ? $signed(32'(i * 1000)) : rand_sample(), 1'b0);
        send_sample(32'sh80000000, 1'b0);
        for (int i = 0; i < 6; i++)
            send_sample(rand_sample(), 1'b0);
        wait_drained();
        send_sample(7, 1'b1);
    endtask

    task automatic test_random_stream(int n);
        for (int i = 0; i < n; i++)
        begin
            if (i % 200 == 0)
                no_gaps = ($urandom_range(2) == 0);
            if (i == n / 2)
                wait_drained();
            send_sample(rand_sample(), ($urandom_range(59) == 0));
        end
        no_gaps = 1'b0;
        wait_drained();
    endtask

    initial
    begin
        heap_n[rmth_pkg::HEAP_LOWER] = 0;
        heap_n[rmth_pkg::HEAP_UPPER] = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_full_store(1'b1);
        test_random_stream(150);
        repeat (200) @(posedge clk);
        $display("%0d transactions sent, %0d results checked, %0d dropped on full store",
                 sent_count, checked_count, drop_count);
        $display("covered extremes, restart, full store and random streams with gaps");
        if (fail_count == 0 && pending_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[sim.f]
hdl/rmth_pkg.sv
hdl/rmth_ram.sv
hdl/rmth_datapath.sv
hdl/rmth_ctrl.sv
hdl/running_median_two_heaps_top.sv
dv/tb_running_median_two_heaps_top.sv
